// ===== hw/rtl/lrp_pkg.sv =====
// Package for the link response parser: phase and op codes, characters, digit helper.
`default_nettype none

package lrp_pkg;

  localparam int LRP_BUFFER_DEPTH = 11;
  localparam int IDX_W = 4;

  typedef enum logic [2:0] {
    PH_IDLE            = 3'd0,
    PH_WAIT_CONNECT    = 3'd1,
    PH_CONNECTED       = 3'd2,
    PH_INCOMING        = 3'd3,
    PH_WAIT_INFO       = 3'd4,
    PH_STORING         = 3'd5,
    PH_STRING_RECEIVED = 3'd6,
    PH_WAIT_DISCONNECT = 3'd7
  } phase_e;

  typedef enum logic [1:0] {
    OP_RX_BYTE = 2'd0,
    OP_CONNECT = 2'd1,
    OP_TIMEOUT = 2'd2
  } op_e;

  localparam logic [7:0] CH_DASH  = 8'h2d;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_C     = 8'h43;
  localparam logic [7:0] CH_I     = 8'h49;
  localparam logic [7:0] CH_LT    = 8'h3c;
  localparam logic [7:0] CH_GT    = 8'h3e;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_N     = 8'h4e;
  localparam logic [7:0] CH_O     = 8'h4f;
  localparam logic [7:0] CH_K     = 8'h4b;
  localparam logic [7:0] TEN      = 8'd10;

  function automatic logic [7:0] two_digits(input logic [7:0] hi, input logic [7:0] lo);
    logic [7:0] h;
    logic [7:0] l;
    h = hi - CH_ZERO;
    l = lo - CH_ZERO;
    return 8'(h * TEN) + l;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/lrp_if.sv =====
// Handshake channels of the link response parser: input beats and result beats.
`default_nettype none

interface lrp_in_if import lrp_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] rx_byte;

  modport source (output valid, output op, output rx_byte, input ready);
  modport sink (input valid, input op, input rx_byte, output ready);
endinterface

interface lrp_out_if import lrp_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [2:0] link_state;
  logic       time_set;
  logic [7:0] day_value;
  logic [7:0] hour_value;
  logic [7:0] minute_value;
  logic [7:0] second_value;
  logic       ok_seen;

  modport source (
    output valid, output link_state, output time_set, output day_value,
    output hour_value, output minute_value, output second_value, output ok_seen,
    input ready
  );
  modport sink (
    input valid, input link_state, input time_set, input day_value,
    input hour_value, input minute_value, input second_value, input ok_seen,
    output ready
  );
endinterface

`default_nettype wire

// ===== hw/rtl/link_response_parser.sv =====
// Link response parser: follows connection messages of a serial network module.
//
// Input channel in_i carries one beat per event: op (received byte, start
// connect, connect timeout) and rx_byte. Output channel out_o returns exactly
// one result beat per input beat, in order: the link phase after the event,
// plus time-set and OK flags with the parsed day, hour, minute and second.
// Bracketed text is kept in a BUFFER_DEPTH-byte store and checked as soon
// as the closing bracket has arrived.
// A beat is held in an input register, then the phase logic and store check
// run in one pass into the result register.
// Throughput is one beat per cycle while the receiver takes each result.
// While the receiver stalls, the input register still takes one more beat;
// after that in_i.ready drops until the result is taken.
// Reset clears the phase, index, byte counter and the whole store at once,
// so no clearing pass is needed; both channels are empty after reset.
`default_nettype none

module link_response_parser import lrp_pkg::*; #(
  parameter int BUFFER_DEPTH = LRP_BUFFER_DEPTH
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  lrp_in_if.sink      in_i,
  lrp_out_if.source   out_o
);

  localparam logic [IDX_W:0] DEPTH_W = (IDX_W + 1)'(BUFFER_DEPTH);

  // input register
  logic       s1_valid_q, s1_valid_d;
  logic [1:0] s1_op_q;
  logic [7:0] s1_byte_q;

  // block state
  phase_e           ph_q, ph_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [1:0]       cnt_q, cnt_d;
  logic [7:0]       store_q [BUFFER_DEPTH];
  logic             we;

  // result register
  logic       out_valid_q;
  phase_e     res_ph_q;
  logic       res_tset_q, res_tset_d;
  logic       res_ok_q, res_ok_d;
  logic [7:0] res_day_q, res_day_d;
  logic [7:0] res_hr_q, res_hr_d;
  logic [7:0] res_mn_q, res_mn_d;
  logic [7:0] res_sc_q, res_sc_d;

  logic       s1_adv;
  logic       in_acc;
  logic       step;
  phase_e     ph_mid;
  phase_e     ph_upd;
  logic [1:0] cnt_sat;
  logic [IDX_W:0] idx_next;

  assign s1_adv     = !out_valid_q || out_o.ready;
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign in_acc     = in_i.valid && in_i.ready;
  assign step       = s1_valid_q && s1_adv;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_acc) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_op_q   <= in_i.op;
      s1_byte_q <= in_i.rx_byte;
    end
  end

  // phase update for the held beat
  always_comb begin
    ph_upd   = ph_q;
    ph_mid   = ph_q;
    idx_d    = idx_q;
    cnt_d    = cnt_q;
    we       = 1'b0;
    cnt_sat  = (cnt_q != 2'd3) ? cnt_q + 2'd1 : cnt_q;
    idx_next = {1'b0, idx_q} + (IDX_W + 1)'(1);
    unique case (s1_op_q)
      OP_RX_BYTE: begin
        cnt_d = cnt_sat;
        priority if (s1_byte_q == CH_C) begin
          if (ph_q == PH_IDLE || ph_q == PH_WAIT_CONNECT) begin
            ph_upd = PH_CONNECTED;
            cnt_d  = 2'd0;
          end
        end else if (s1_byte_q == CH_I) begin
          if (ph_q == PH_CONNECTED && cnt_sat == 2'd1) begin
            ph_upd = PH_INCOMING;
          end
        end else if (s1_byte_q == CH_LT) begin
          if (ph_q == PH_WAIT_INFO) begin
            ph_upd = PH_STORING;
          end
        end else begin
          if (s1_byte_q == CH_GT && ph_q == PH_STORING) begin
            ph_mid = PH_STRING_RECEIVED;
          end
          ph_upd = ph_mid;
          unique case (ph_mid)
            PH_CONNECTED: ph_upd = PH_WAIT_INFO;
            PH_STORING: begin
              we = {1'b0, idx_q} < DEPTH_W;
              if (idx_next >= DEPTH_W) begin
                ph_upd = PH_WAIT_DISCONNECT;
              end
              idx_d = idx_next[IDX_W-1:0];
            end
            PH_STRING_RECEIVED, PH_WAIT_DISCONNECT, PH_INCOMING: begin
              if (s1_byte_q == CH_D) begin
                ph_upd = PH_IDLE;
                idx_d  = '0;
              end
            end
            PH_WAIT_CONNECT: begin
              if (s1_byte_q == CH_N || s1_byte_q == CH_D) begin
                ph_upd = PH_IDLE;
                idx_d  = '0;
              end
            end
            default: ;
          endcase
        end
      end
      OP_CONNECT: begin
        if (ph_q == PH_IDLE) begin
          ph_upd = PH_WAIT_CONNECT;
        end
      end
      OP_TIMEOUT: begin
        if (ph_q == PH_WAIT_CONNECT) begin
          ph_upd = PH_IDLE;
        end
      end
      default: ;
    endcase
  end

  // store check; no store write can coincide with the string received phase
  always_comb begin
    ph_d       = ph_upd;
    res_tset_d = 1'b0;
    res_ok_d   = 1'b0;
    res_day_d  = '0;
    res_hr_d   = '0;
    res_mn_d   = '0;
    res_sc_d   = '0;
    if (ph_upd == PH_STRING_RECEIVED) begin
      priority if (store_q[1] == CH_DASH && store_q[4] == CH_COLON) begin
        ph_d       = PH_WAIT_DISCONNECT;
        res_tset_d = 1'b1;
        res_day_d  = store_q[0] - CH_ZERO;
        res_hr_d   = two_digits(store_q[2], store_q[3]);
        res_mn_d   = two_digits(store_q[5], store_q[6]);
        res_sc_d   = two_digits(store_q[8], store_q[9]);
      end else if (store_q[0] == CH_O && store_q[1] == CH_K) begin
        ph_d     = PH_WAIT_DISCONNECT;
        res_ok_d = 1'b1;
      end else begin
        // no match: keep waiting in string received
        ph_d = PH_STRING_RECEIVED;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q  <= PH_IDLE;
      idx_q <= '0;
      cnt_q <= '0;
      for (int i = 0; i < BUFFER_DEPTH; i++) begin
        store_q[i] <= '0;
      end
    end else if (step) begin
      ph_q  <= ph_d;
      idx_q <= idx_d;
      cnt_q <= cnt_d;
      for (int i = 0; i < BUFFER_DEPTH; i++) begin
        if (we && idx_q == IDX_W'(i)) begin
          store_q[i] <= s1_byte_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_ph_q   <= ph_d;
      res_tset_q <= res_tset_d;
      res_ok_q   <= res_ok_d;
      res_day_q  <= res_day_d;
      res_hr_q   <= res_hr_d;
      res_mn_q   <= res_mn_d;
      res_sc_q   <= res_sc_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.link_state   = res_ph_q;
  assign out_o.time_set     = res_tset_q;
  assign out_o.ok_seen      = res_ok_q;
  assign out_o.day_value    = res_day_q;
  assign out_o.hour_value   = res_hr_q;
  assign out_o.minute_value = res_mn_q;
  assign out_o.second_value = res_sc_q;

  a_match_leaves_wait_disc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (res_tset_q || res_ok_q) |-> res_ph_q == PH_WAIT_DISCONNECT)
    else $error("match result without wait disconnect phase");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(res_tset_q && res_ok_q))
    else $error("time set and OK reported together");

  a_index_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ph_q == PH_STORING |-> {1'b0, idx_q} < DEPTH_W)
    else $error("store index past depth while storing");

  a_beat_reaches_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_valid_q)
    else $error("processed beat did not reach the result register");

endmodule

`default_nettype wire

// ===== test/tb_link_response_parser.sv =====
// Self-checking testbench for link_response_parser: directed table, random sessions, stalls.
`timescale 1ns / 100ps

module tb_link_response_parser;
  import lrp_pkg::*;

  localparam logic [1:0] OP_UNDEFINED = 2'd3;
  localparam int STIM_TOTAL = 1450;
  localparam int HOLD_CYCLES = 64;

  typedef struct packed {
    logic [2:0] link_state;
    logic       time_set;
    logic [7:0] day_value;
    logic [7:0] hour_value;
    logic [7:0] minute_value;
    logic [7:0] second_value;
    logic       ok_seen;
  } link_result_t;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] rx;
    logic       typed;
    logic [2:0] want_phase;
    logic       want_ok;
  } link_beat_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  always #5 clk_i = ~clk_i;

  lrp_in_if  in_if ();
  lrp_out_if out_if ();

  link_response_parser u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // directed beats; typed rows carry their expected phase and OK flag
  link_beat_t dir_tab [30] = '{
    '{OP_TIMEOUT,   8'h00, 1'b1, PH_IDLE,            1'b0},
    '{OP_UNDEFINED, 8'hff, 1'b1, PH_IDLE,            1'b0},
    '{OP_CONNECT,   8'h00, 1'b1, PH_WAIT_CONNECT,    1'b0},
    '{OP_RX_BYTE,   CH_N,  1'b1, PH_IDLE,            1'b0},
    '{OP_CONNECT,   8'h00, 1'b1, PH_WAIT_CONNECT,    1'b0},
    '{OP_TIMEOUT,   8'h00, 1'b1, PH_IDLE,            1'b0},
    '{OP_RX_BYTE,   CH_C,  1'b1, PH_CONNECTED,       1'b0},
    '{OP_RX_BYTE,   CH_I,  1'b1, PH_INCOMING,        1'b0},
    '{OP_RX_BYTE,   CH_D,  1'b1, PH_IDLE,            1'b0},
    '{OP_RX_BYTE,   CH_C,  1'b1, PH_CONNECTED,       1'b0},
    '{OP_RX_BYTE,   8'h00, 1'b1, PH_WAIT_INFO,       1'b0},
    '{OP_RX_BYTE,   CH_LT, 1'b1, PH_STORING,         1'b0},
    '{OP_RX_BYTE,   CH_O,  1'b0, 3'd0,               1'b0},
    '{OP_RX_BYTE,   CH_K,  1'b0, 3'd0,               1'b0},
    '{OP_RX_BYTE,   CH_GT, 1'b1, PH_WAIT_DISCONNECT, 1'b1},
    '{OP_RX_BYTE,   CH_D,  1'b1, PH_IDLE,            1'b0},
    '{OP_RX_BYTE,   CH_C,  1'b0, 3'd0,               1'b0},
    '{OP_RX_BYTE,   8'hff, 1'b0, 3'd0,               1'b0},
    '{OP_RX_BYTE,   CH_LT, 1'b0, 3'd0,               1'b0},
    '{OP_RX_BYTE,   CH_ZERO + 8'd9, 1'b0, 3'd0,      1'b0},
    '{OP_RX_BYTE,   CH_DASH,        1'b0, 3'd0,      1'b0},
    '{OP_RX_BYTE,   CH_ZERO + 8'd2, 1'b0, 3'd0,      1'b0},
    '{OP_RX_BYTE,   CH_ZERO + 8'd3, 1'b0, 3'd0,      1'b0},
    '{OP_RX_BYTE,   CH_COLON,       1'b0, 3'd0,      1'b0},
    '{OP_RX_BYTE,   CH_ZERO + 8'd5, 1'b0, 3'd0,      1'b0},
    '{OP_RX_BYTE,   CH_ZERO + 8'd9, 1'b0, 3'd0,      1'b0},
    '{OP_RX_BYTE,   CH_COLON,       1'b0, 3'd0,      1'b0},
    '{OP_RX_BYTE,   CH_ZERO + 8'd5, 1'b0, 3'd0,      1'b0},
    '{OP_RX_BYTE,   CH_ZERO + 8'd9, 1'b0, 3'd0,      1'b0},
    '{OP_RX_BYTE,   CH_GT,          1'b0, 3'd0,      1'b0}
  };

  link_beat_t   stim_q [$];
  link_result_t result_q [$];

  // predictor state
  phase_e     lp_phase;
  logic [3:0] lp_index;
  logic [1:0] lp_count;
  logic [7:0] lp_store [16];

  int idle_mode;
  bit hold_req;
  int mismatch_cnt;
  int beats_seen;
  int clock_hits;
  int ok_hits;
  int hold_total;

  function automatic void queue_beat(input logic [1:0] op, input logic [7:0] rx);
    stim_q.push_back('{op, rx, 1'b0, 3'd0, 1'b0});
  endfunction

  // a byte that the store keeps as it is
  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    do b = 8'($urandom); while (b == CH_C || b == CH_I || b == CH_LT || b == CH_GT);
    return b;
  endfunction

  function automatic logic [7:0] digit_byte();
    if ($urandom_range(0, 7) == 0) return text_byte();
    return CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] pair_value(input logic [7:0] hi, input logic [7:0] lo);
    return 8'((int'(hi) - int'(CH_ZERO)) * int'(TEN) + (int'(lo) - int'(CH_ZERO)));
  endfunction

  function automatic link_result_t predict_link(input logic [1:0] op, input logic [7:0] b);
    link_result_t r;
    r = '0;
    if (op == OP_RX_BYTE) begin
      if (lp_count != 2'd3) lp_count = lp_count + 2'd1;
      if (b == CH_C) begin
        if (lp_phase == PH_IDLE || lp_phase == PH_WAIT_CONNECT) begin
          lp_phase = PH_CONNECTED;
          lp_count = 2'd0;
        end
      end else if (b == CH_I) begin
        if (lp_phase == PH_CONNECTED && lp_count == 2'd1) lp_phase = PH_INCOMING;
      end else if (b == CH_LT) begin
        if (lp_phase == PH_WAIT_INFO) lp_phase = PH_STORING;
      end else begin
        if (b == CH_GT && lp_phase == PH_STORING) lp_phase = PH_STRING_RECEIVED;
        case (lp_phase)
          PH_CONNECTED: lp_phase = PH_WAIT_INFO;
          PH_STORING: begin
            if (int'(lp_index) < LRP_BUFFER_DEPTH) lp_store[lp_index] = b;
            if (int'(lp_index) + 1 >= LRP_BUFFER_DEPTH) lp_phase = PH_WAIT_DISCONNECT;
            lp_index = lp_index + 4'd1;
          end
          PH_STRING_RECEIVED, PH_WAIT_DISCONNECT, PH_INCOMING: begin
            if (b == CH_D) begin
              lp_phase = PH_IDLE;
              lp_index = 4'd0;
            end
          end
          PH_WAIT_CONNECT: begin
            if (b == CH_N || b == CH_D) begin
              lp_phase = PH_IDLE;
              lp_index = 4'd0;
            end
          end
          default: ;
        endcase
      end
    end else if (op == OP_CONNECT) begin
      if (lp_phase == PH_IDLE) lp_phase = PH_WAIT_CONNECT;
    end else if (op == OP_TIMEOUT) begin
      if (lp_phase == PH_WAIT_CONNECT) lp_phase = PH_IDLE;
    end

    if (lp_phase == PH_STRING_RECEIVED) begin
      if (lp_store[1] == CH_DASH && lp_store[4] == CH_COLON) begin
        lp_phase       = PH_WAIT_DISCONNECT;
        r.time_set     = 1'b1;
        r.day_value    = lp_store[0] - CH_ZERO;
        r.hour_value   = pair_value(lp_store[2], lp_store[3]);
        r.minute_value = pair_value(lp_store[5], lp_store[6]);
        r.second_value = pair_value(lp_store[8], lp_store[9]);
      end else if (lp_store[0] == CH_O && lp_store[1] == CH_K) begin
        lp_phase  = PH_WAIT_DISCONNECT;
        r.ok_seen = 1'b1;
      end
    end
    r.link_state = lp_phase;
    return r;
  endfunction

  // sender
  initial begin
    int pick;
    int gap_pct;
    int n_dir;
    link_result_t want;

    rst_ni        = 1'b0;
    in_if.valid   = 1'b0;
    in_if.op      = OP_RX_BYTE;
    in_if.rx_byte = 8'h00;
    idle_mode     = 0;
    hold_req      = 1'b0;

    lp_phase = PH_IDLE;
    lp_index = 4'd0;
    lp_count = 2'd0;
    foreach (lp_store[k]) lp_store[k] = 8'h00;

    foreach (dir_tab[k]) stim_q.push_back(dir_tab[k]);
    n_dir = stim_q.size();

    while (stim_q.size() < STIM_TOTAL) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        queue_beat(OP_RX_BYTE, CH_C);
        if ($urandom_range(0, 4) == 0) begin
          queue_beat(OP_RX_BYTE, CH_I);
          repeat ($urandom_range(0, 3)) queue_beat(OP_RX_BYTE, text_byte());
          queue_beat(OP_RX_BYTE, CH_D);
        end else begin
          queue_beat(OP_RX_BYTE, ($urandom_range(0, 7) == 0) ? CH_GT : text_byte());
          queue_beat(OP_RX_BYTE, CH_LT);
          case ($urandom_range(0, 3))
            0: begin
              queue_beat(OP_RX_BYTE, digit_byte());
              queue_beat(OP_RX_BYTE, ($urandom_range(0, 5) == 0) ? text_byte() : CH_DASH);
              queue_beat(OP_RX_BYTE, digit_byte());
              queue_beat(OP_RX_BYTE, digit_byte());
              queue_beat(OP_RX_BYTE, ($urandom_range(0, 5) == 0) ? text_byte() : CH_COLON);
              queue_beat(OP_RX_BYTE, digit_byte());
              queue_beat(OP_RX_BYTE, digit_byte());
              queue_beat(OP_RX_BYTE, CH_COLON);
              queue_beat(OP_RX_BYTE, digit_byte());
              queue_beat(OP_RX_BYTE, digit_byte());
              if ($urandom_range(0, 2) == 0) queue_beat(OP_RX_BYTE, text_byte());
              queue_beat(OP_RX_BYTE, CH_GT);
            end
            1: begin
              queue_beat(OP_RX_BYTE, CH_O);
              queue_beat(OP_RX_BYTE, CH_K);
              repeat ($urandom_range(0, 8)) queue_beat(OP_RX_BYTE, text_byte());
              queue_beat(OP_RX_BYTE, CH_GT);
            end
            2: begin
              repeat ($urandom_range(0, 10)) queue_beat(OP_RX_BYTE, text_byte());
              queue_beat(OP_RX_BYTE, CH_GT);
            end
            default: begin
              // overrun of the store
              repeat ($urandom_range(11, 13)) queue_beat(OP_RX_BYTE, text_byte());
              if ($urandom_range(0, 1) == 0) queue_beat(OP_RX_BYTE, CH_GT);
            end
          endcase
          if ($urandom_range(0, 7) != 0) queue_beat(OP_RX_BYTE, CH_D);
          else queue_beat(2'($urandom_range(0, 3)), 8'($urandom));
        end
      end else if (pick < 75) begin
        queue_beat(OP_CONNECT, 8'($urandom));
        case ($urandom_range(0, 4))
          0:       queue_beat(OP_RX_BYTE, CH_N);
          1:       queue_beat(OP_RX_BYTE, CH_D);
          2:       queue_beat(OP_TIMEOUT, 8'($urandom));
          3:       queue_beat(OP_RX_BYTE, 8'($urandom));
          default: queue_beat(OP_CONNECT, 8'($urandom));
        endcase
      end else begin
        repeat ($urandom_range(1, 4)) queue_beat(2'($urandom_range(0, 3)), 8'($urandom));
      end
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < stim_q.size(); i++) begin
      idle_mode = (i * 4) / stim_q.size();
      if (i == stim_q.size() / 8) hold_req = 1'b1;
      gap_pct = (idle_mode == 1) ? 45 : (idle_mode == 3) ? 8 : 0;
      while ($urandom_range(0, 99) < gap_pct) begin
        in_if.valid <= 1'b0;
        @(posedge clk_i);
      end
      in_if.valid   <= 1'b1;
      in_if.op      <= stim_q[i].op;
      in_if.rx_byte <= stim_q[i].rx;
      do @(posedge clk_i); while (!in_if.ready);
      want = predict_link(stim_q[i].op, stim_q[i].rx);
      if (stim_q[i].typed) begin
        want = '{link_state: stim_q[i].want_phase, time_set: 1'b0, day_value: 8'd0,
                 hour_value: 8'd0, minute_value: 8'd0, second_value: 8'd0,
                 ok_seen: stim_q[i].want_ok};
      end
      result_q.push_back(want);
    end
    in_if.valid <= 1'b0;
    idle_mode = 0;

    while (result_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("%0d beats (%0d directed), %0d time strings, %0d OK strings checked",
             beats_seen, n_dir, clock_hits, ok_hits);
    $display("receiver held off for %0d cycles with the sender offering", hold_total);
    if (mismatch_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // receiver and result check
  initial begin
    int hold_left;
    link_result_t got;
    link_result_t want;

    hold_left    = 0;
    mismatch_cnt = 0;
    beats_seen   = 0;
    clock_hits   = 0;
    ok_hits      = 0;
    hold_total   = 0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_if.valid && out_if.ready) begin
        got = '{out_if.link_state, out_if.time_set, out_if.day_value, out_if.hour_value,
                out_if.minute_value, out_if.second_value, out_if.ok_seen};
        if (result_q.size() == 0) begin
          if (mismatch_cnt < 10) $display("result beat with nothing expected: %h", got);
          mismatch_cnt++;
        end else begin
          want = result_q.pop_front();
          if (got !== want) begin
            if (mismatch_cnt < 10) begin
              $display("beat %0d: exp phase %0d ts %0b d %0d h %0d m %0d s %0d ok %0b",
                       beats_seen, want.link_state, want.time_set, want.day_value,
                       want.hour_value, want.minute_value, want.second_value, want.ok_seen);
              $display("beat %0d: got phase %0d ts %0b d %0d h %0d m %0d s %0d ok %0b",
                       beats_seen, got.link_state, got.time_set, got.day_value,
                       got.hour_value, got.minute_value, got.second_value, got.ok_seen);
            end
            mismatch_cnt++;
          end
          clock_hits += want.time_set;
          ok_hits    += want.ok_seen;
        end
        beats_seen++;
      end
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        hold_total++;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(0, 99) >=
                         ((idle_mode == 2) ? 45 : (idle_mode == 3) ? 8 : 0));
      end
    end
  end

  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
